[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: always");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/mct_pkg.sv]
// ---------------------------------------------------------------------------
// mct_pkg
// Request codes, result kinds, field widths and stream payload layouts of
// the multi-channel compare timer.
// ---------------------------------------------------------------------------
package mct_pkg;

  // Field widths
  localparam int REQ_W       = 2;
  localparam int CHAN_W      = 2;
  localparam int DELAY_W     = 24;
  localparam int PRESCALE_W  = 12;
  localparam int MASK_W      = 4;
  localparam int COUNT_OUT_W = 24;

  // Request codes (slave tuser)
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // Result kinds (master tuser)
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Input payload, first field in the highest bits
  typedef struct packed {
    logic [DELAY_W-1:0] delay_ticks;
    logic               periodic;
    logic [CHAN_W-1:0]  channel;
  } in_item_t;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count_value;
    logic                   counter_running;
    logic [MASK_W-1:0]      active_mask;
    logic [CHAN_W-1:0]      fired_channel;
  } res_item_t;

  localparam int IN_DATA_W   = $bits(in_item_t);
  localparam int RES_DATA_W  = $bits(res_item_t);
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RES_DATA_W + 7) / 8) * 8;

endpackage

[rtl/multi_channel_compare_timer.sv]
// ---------------------------------------------------------------------------
// multi_channel_compare_timer
// Shared counter with compare channels started one-shot or periodic. Compare
// values and reload periods live in two synchronous memories; ticks scan
// them and emit one expiry per matching channel.
// ---------------------------------------------------------------------------
//
//  port group   direction  payload
//  s_*          in         tuser: req_type; tdata: channel, periodic,
//                          delay_ticks
//  m_*          out        tuser: result_kind; tlast: last; tdata:
//                          fired_channel, active_mask, counter_running,
//                          count_value
//  cfg_wr_*     in         tick_prescale
//
//  Start and stop pass through ST_ACK; a tick that only advances the
//  prescaler stays in ST_IDLE; a tick that advances the counter runs the
//  compare scan in ST_SCAN, then ST_FIRE_RD and ST_FIRE_EV per expiry, all
//  set by the single read port of the compare and period memories.
//  Reset is synchronous; the memories need no clearing pass.
//  A result waits in the output register while the next item is accepted;
//  a stalled master side holds the block at its next result.
// ---------------------------------------------------------------------------
module multi_channel_compare_timer #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // slave stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: channel[1:0], periodic[2], delay_ticks[26:3], zero pad
  input  logic [mct_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tuser: req_type[1:0]
  input  logic [mct_pkg::REQ_W-1:0]         s_tuser,
  // master stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: fired_channel[1:0], active_mask[5:2], counter_running[6],
  //        count_value[30:7], zero pad
  output logic [mct_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // tuser: result_kind[0]
  output logic [0:0]                        m_tuser,
  output logic                              m_tlast,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [mct_pkg::PRESCALE_W-1:0]    cfg_wr_data
);
  import mct_pkg::*;

  `include "assert_macros.svh"

  localparam int USED_CH = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam int IDX_W   = (USED_CH > 1) ? $clog2(USED_CH) : 1;
  localparam int SCAN_W  = $clog2(USED_CH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SCAN,
    ST_FIRE_RD,
    ST_FIRE_EV
  } state_t;

  // Control registers
  state_t                  state;
  logic [COUNT_BITS-1:0]   count;
  logic [PRESCALE_W-1:0]   prescale_count;
  logic [PRESCALE_W-1:0]   tick_prescale;
  logic                    running;
  logic [MASK_W-1:0]       channel_active;
  logic [MASK_W-1:0]       hits;
  logic [SCAN_W-1:0]       scan_idx;
  logic                    ev_valid;
  logic [CHAN_W-1:0]       ev_ch;
  logic [CHAN_W-1:0]       ack_ch;

  // Output register
  res_item_t               out_res;
  logic                    out_kind;
  logic                    out_last;

  // Memories
  logic [COUNT_BITS-1:0]   cmp_mem [USED_CH];
  logic [COUNT_BITS-1:0]   rel_mem [USED_CH];
  logic [COUNT_BITS-1:0]   cmp_rd;
  logic [COUNT_BITS-1:0]   rel_rd;
  logic [IDX_W-1:0]        rd_addr;
  logic                    cmp_we;
  logic [IDX_W-1:0]        cmp_waddr;
  logic [COUNT_BITS-1:0]   cmp_wdata;
  logic                    rel_we;
  logic [COUNT_BITS-1:0]   rel_wdata;

  // Decode and datapath
  in_item_t                in_item;
  logic                    accept;
  logic                    ch_ok;
  logic                    start_go;
  logic                    stop_go;
  logic [IDX_W-1:0]        in_idx;
  logic [COUNT_BITS-1:0]   delay_c;
  logic [MASK_W-1:0]       in_bit;
  logic [CHAN_W-1:0]       fire_ch;
  logic [MASK_W-1:0]       fire_bit;
  logic [MASK_W-1:0]       hits_rest;
  logic                    fire_oneshot;
  logic [MASK_W-1:0]       act_after_fire;
  logic                    out_free;
  logic                    fire_go;
  logic                    out_load;
  logic                    scan_done;
  logic                    hit_now;
  logic [MASK_W-1:0]       hits_upd;

  // Decode the request and steer memory accesses
  always_comb begin
    in_item   = in_item_t'(s_tdata[IN_DATA_W-1:0]);
    accept    = s_tvalid && s_tready;
    ch_ok     = 32'(in_item.channel) < USED_CH;
    start_go  = accept && (s_tuser == REQ_START) && ch_ok;
    stop_go   = accept && (s_tuser == REQ_STOP) && ch_ok;
    in_idx    = in_item.channel[IDX_W-1:0];
    delay_c   = COUNT_BITS'(in_item.delay_ticks);
    in_bit    = MASK_W'(1) << in_item.channel;

    // lowest pending expiry first
    fire_ch = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (hits[i]) begin
        fire_ch = CHAN_W'(i);
      end
    end
    fire_bit       = MASK_W'(1) << fire_ch;
    hits_rest      = hits & ~fire_bit;
    fire_oneshot   = (rel_rd == '0);
    act_after_fire = fire_oneshot ? (channel_active & ~fire_bit) : channel_active;
    out_free       = !m_tvalid || m_tready;
    fire_go        = (state == ST_FIRE_EV) && out_free;
    out_load       = ((state == ST_ACK) && out_free) || fire_go;

    scan_done = (scan_idx == SCAN_W'(USED_CH));
    hit_now   = ev_valid && channel_active[ev_ch] && (cmp_rd == count);
    hits_upd  = hits | ({MASK_W{hit_now}} & (MASK_W'(1) << ev_ch));

    rd_addr   = (state == ST_SCAN) ? scan_idx[IDX_W-1:0] : fire_ch[IDX_W-1:0];
    cmp_we    = start_go || (fire_go && !fire_oneshot);
    cmp_waddr = start_go ? in_idx : fire_ch[IDX_W-1:0];
    cmp_wdata = start_go ? (count + delay_c) : (cmp_rd + rel_rd);
    rel_we    = start_go || stop_go;
    rel_wdata = (start_go && in_item.periodic) ? delay_c : '0;
  end

  // Compare memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmp_we) begin
      cmp_mem[cmp_waddr] <= cmp_wdata;
    end
    cmp_rd <= cmp_mem[rd_addr];
  end

  // Reload period memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[in_idx] <= rel_wdata;
    end
    rel_rd <= rel_mem[rd_addr];
  end

  // Sequencer, timer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      prescale_count <= '0;
      tick_prescale  <= '0;
      running        <= 1'b0;
      channel_active <= '0;
      hits           <= '0;
      scan_idx       <= '0;
      ev_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tick_prescale <= cfg_wr_data;
      end

      // load a new result, or drop the one just transferred
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            ack_ch <= in_item.channel;
            if (s_tuser == REQ_TICK) begin
              if (running) begin
                if (prescale_count >= tick_prescale) begin
                  prescale_count <= '0;
                  count          <= count + COUNT_BITS'(1);
                  scan_idx       <= '0;
                  ev_valid       <= 1'b0;
                  hits           <= '0;
                  state          <= ST_SCAN;
                end else begin
                  prescale_count <= prescale_count + PRESCALE_W'(1);
                end
              end
            end else if (start_go) begin
              if (channel_active == '0) begin
                prescale_count <= '0;
              end
              running        <= 1'b1;
              channel_active <= channel_active | in_bit;
              state          <= ST_ACK;
            end else if (stop_go) begin
              channel_active <= channel_active & ~in_bit;
              if ((channel_active & ~in_bit) == '0) begin
                running        <= 1'b0;
                prescale_count <= '0;
              end
              state <= ST_ACK;
            end
          end
        end

        ST_ACK: begin
          if (out_free) begin
            out_kind                <= KIND_ACK;
            out_last                <= 1'b1;
            out_res.fired_channel   <= ack_ch;
            out_res.active_mask     <= channel_active;
            out_res.counter_running <= running;
            out_res.count_value     <= COUNT_OUT_W'(count);
            state                   <= ST_IDLE;
          end
        end

        ST_SCAN: begin
          // advance the read address, evaluate the entry read last cycle
          if (!scan_done) begin
            ev_valid <= 1'b1;
            ev_ch    <= CHAN_W'(scan_idx);
            scan_idx <= scan_idx + SCAN_W'(1);
          end else begin
            ev_valid <= 1'b0;
          end
          hits <= hits_upd;
          if (scan_done && ev_valid) begin
            state <= (hits_upd != '0) ? ST_FIRE_RD : ST_IDLE;
          end
        end

        ST_FIRE_RD: begin
          state <= ST_FIRE_EV;
        end

        ST_FIRE_EV: begin
          // hold until the output register is free
          if (out_free) begin
            channel_active <= act_after_fire;
            if (act_after_fire == '0) begin
              running        <= 1'b0;
              prescale_count <= '0;
            end
            hits                    <= hits_rest;
            out_kind                <= KIND_EXPIRY;
            out_last                <= (hits_rest == '0);
            out_res.fired_channel   <= fire_ch;
            out_res.active_mask     <= act_after_fire;
            out_res.counter_running <= running && (act_after_fire != '0);
            out_res.count_value     <= COUNT_OUT_W'(count);
            state                   <= (hits_rest == '0) ? ST_IDLE : ST_FIRE_RD;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Ports
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = OUT_TDATA_W'(out_res);
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // Checks
  `ASSERT_ALWAYS(a_run_tracks_active, clk, rst, running == (channel_active != '0))
  `ASSERT_IMPLIES(a_halt_clears_prescale, clk, rst, !running, prescale_count == '0)
  `ASSERT_IMPLIES(a_fire_has_hit, clk, rst, state == ST_FIRE_RD, hits != '0)
  `ASSERT_IMPLIES(a_hits_are_active, clk, rst, state == ST_FIRE_EV, (hits & ~channel_active) == '0)
  `ASSERT_NEXT(a_ack_follows_cmd, clk, rst, start_go || stop_go, state == ST_ACK)

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stream-level test of the multi-channel compare timer. A short table of
// directed requests comes first, then random tick, start and stop traffic
// under several prescale settings. Each result is checked against an
// in-bench predictor of the shared counter and its channels. Both sides
// idle at random, and a long output stall fills the block.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mct_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 200;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // One expected result
  typedef struct packed {
    logic                   kind;
    logic [CHAN_W-1:0]      chan;
    logic [MASK_W-1:0]      mask;
    logic                   run;
    logic [COUNT_OUT_W-1:0] cnt;
    logic                   last;
  } timer_event_t;

  // One directed request, with an optional typed-in expectation
  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [CHAN_W-1:0]  chan;
    logic               per;
    logic [DELAY_W-1:0] delay;
    logic               typed;
    logic               t_has;
    timer_event_t       t_ev;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [PRESCALE_W-1:0]  cfg_wr_data = '0;

  multi_channel_compare_timer u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Predicted timer state
  logic [COUNT_OUT_W-1:0] tmr_count = '0;
  logic [PRESCALE_W-1:0]  tmr_div = '0;
  logic [PRESCALE_W-1:0]  div_limit = '0;
  logic                   tmr_on = 1'b0;
  logic [MASK_W-1:0]      tmr_act = '0;
  logic [DELAY_W-1:0]     tmr_cmp [4];
  logic [DELAY_W-1:0]     tmr_reload [4];

  timer_event_t expected_events [$];
  stim_row_t    directed_rows [$];
  int           errors = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           stall_left = 0;
  bit           stall_request = 1'b0;

  // Item on offer: typed-in expectation travels with it
  logic         cur_typed = 1'b0;
  logic         cur_t_has = 1'b0;
  timer_event_t cur_t_ev = '0;

  in_item_t     seen_in;
  res_item_t    seen_out;
  timer_event_t exp_ev;

  initial begin
    for (int i = 0; i < 4; i++) begin
      tmr_cmp[i] = '0;
      tmr_reload[i] = '0;
    end
  end

  function automatic timer_event_t make_event(logic kind, logic [CHAN_W-1:0] ch);
    timer_event_t ev;
    ev.kind = kind;
    ev.chan = ch;
    ev.mask = tmr_act;
    ev.run  = tmr_on;
    ev.cnt  = tmr_count;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance the predicted timer by one request; queue its results if asked
  function automatic void timer_step(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch,
                                     logic per, logic [DELAY_W-1:0] delay, bit keep);
    logic [3:0]   hits;
    timer_event_t burst [4];
    int           n;
    n = 0;
    hits = '0;
    case (req)
      REQ_TICK: begin
        if (tmr_on) begin
          if (tmr_div >= div_limit) begin
            tmr_div = '0;
            tmr_count = tmr_count + 1'b1;
            // decide all matches against the new count first
            for (int i = 0; i < 4; i++)
              hits[i] = tmr_act[i] && (tmr_cmp[i] == tmr_count);
            for (int i = 0; i < 4; i++) begin
              if (hits[i]) begin
                if (tmr_reload[i] == '0) begin
                  tmr_act[i] = 1'b0;
                  if (tmr_act == '0) begin
                    tmr_on = 1'b0;
                    tmr_div = '0;
                  end
                end else begin
                  tmr_cmp[i] = tmr_cmp[i] + tmr_reload[i];
                end
                burst[n] = make_event(KIND_EXPIRY, CHAN_W'(i));
                n++;
              end
            end
          end else begin
            tmr_div = tmr_div + 1'b1;
          end
        end
      end
      REQ_START: begin
        tmr_reload[ch] = per ? delay : '0;
        tmr_cmp[ch] = tmr_count + delay;
        if (tmr_act == '0) begin
          tmr_on = 1'b1;
          tmr_div = '0;
        end
        tmr_act[ch] = 1'b1;
        burst[0] = make_event(KIND_ACK, ch);
        n = 1;
      end
      REQ_STOP: begin
        tmr_reload[ch] = '0;
        tmr_act[ch] = 1'b0;
        if (tmr_act == '0) begin
          tmr_on = 1'b0;
          tmr_div = '0;
        end
        burst[0] = make_event(KIND_ACK, ch);
        n = 1;
      end
      default: begin
      end
    endcase
    if (keep) begin
      for (int i = 0; i < n; i++) begin
        burst[i].last = (i == n - 1);
        expected_events.push_back(burst[i]);
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en)
        div_limit = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        seen_in = s_tdata[IN_DATA_W-1:0];
        timer_step(s_tuser, seen_in.channel, seen_in.periodic, seen_in.delay_ticks,
                   !cur_typed);
        if (cur_typed && cur_t_has)
          expected_events.push_back(cur_t_ev);
      end
      if (m_tvalid && m_tready) begin
        seen_out = m_tdata[RES_DATA_W-1:0];
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0h ch %0h cnt %0h",
                   $time, m_tuser[0], seen_out.fired_channel, seen_out.count_value);
          errors++;
        end else begin
          exp_ev = expected_events.pop_front();
          check_field("result_kind", 32'(exp_ev.kind), 32'(m_tuser[0]));
          check_field("fired_channel", 32'(exp_ev.chan), 32'(seen_out.fired_channel));
          check_field("active_mask", 32'(exp_ev.mask), 32'(seen_out.active_mask));
          check_field("counter_running", 32'(exp_ev.run), 32'(seen_out.counter_running));
          check_field("count_value", 32'(exp_ev.cnt), 32'(seen_out.count_value));
          check_field("last", 32'(exp_ev.last), 32'(m_tlast));
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_left = HOLD_CYCLES;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer; entered at a falling edge
  task automatic send_item(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch, logic per,
                           logic [DELAY_W-1:0] delay, logic typed, logic t_has,
                           timer_event_t t_ev);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    it.delay_ticks = delay;
    it.periodic = per;
    it.channel = ch;
    s_tdata = '0;
    s_tdata[IN_DATA_W-1:0] = it;
    s_tuser = req;
    cur_typed = typed;
    cur_t_has = t_has;
    cur_t_ev = t_ev;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [REQ_W-1:0]   req;
    logic [DELAY_W-1:0] delay;
    int                 pick;
    pick = int'($urandom_range(99));
    if (pick < 58)
      req = REQ_TICK;
    else if (pick < 83)
      req = REQ_START;
    else if (pick < 95)
      req = REQ_STOP;
    else
      req = REQ_UNUSED;
    // mostly short delays so that channels expire; some full-range ones
    pick = int'($urandom_range(99));
    if (pick < 70)
      delay = DELAY_W'($urandom_range(12));
    else if (pick < 90)
      delay = DELAY_W'($urandom_range(300, 13));
    else
      delay = DELAY_W'($urandom);
    send_item(req, CHAN_W'($urandom_range(3)), 1'($urandom_range(1)), delay,
              1'b0, 1'b0, '0);
  endtask

  task automatic random_run(int n, bit with_hold);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2)
        stall_request = 1'b1;
      random_item();
    end
  endtask

  // Let every expected result arrive, then let the block settle
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_prescale(logic [PRESCALE_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic add_row(logic [REQ_W-1:0] req, logic [CHAN_W-1:0] ch, logic per,
                         logic [DELAY_W-1:0] delay, logic typed, logic t_has,
                         logic [MASK_W-1:0] t_mask, logic t_run);
    stim_row_t row;
    row.req = req;
    row.chan = ch;
    row.per = per;
    row.delay = delay;
    row.typed = typed;
    row.t_has = t_has;
    row.t_ev.kind = KIND_ACK;
    row.t_ev.chan = ch;
    row.t_ev.mask = t_mask;
    row.t_ev.run = t_run;
    row.t_ev.cnt = '0;
    row.t_ev.last = 1'b1;
    directed_rows.push_back(row);
  endtask

  initial begin
    // tick while stopped, unused code, stop of an idle channel
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b1, 1'b0, 4'b0000, 1'b0);
    add_row(REQ_UNUSED, 2'd0, 1'b0, 24'd5,       1'b1, 1'b0, 4'b0000, 1'b0);
    add_row(REQ_STOP,   2'd3, 1'b0, 24'd0,       1'b1, 1'b1, 4'b0000, 1'b0);
    // first starts after reset
    add_row(REQ_START,  2'd0, 1'b0, 24'd2,       1'b1, 1'b1, 4'b0001, 1'b1);
    add_row(REQ_START,  2'd1, 1'b1, 24'd1,       1'b1, 1'b1, 4'b0011, 1'b1);
    // periodic reload, then two expiries on one tick
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    // periodic with zero period, full-range delay, restart of an active channel
    add_row(REQ_START,  2'd2, 1'b1, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_START,  2'd3, 1'b0, 24'hFFFFFF,  1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_START,  2'd1, 1'b0, 24'd2,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    // all four channels on one compare value: four expiries on one tick
    add_row(REQ_START,  2'd0, 1'b1, 24'd4,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_START,  2'd1, 1'b0, 24'd4,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_START,  2'd2, 1'b1, 24'd4,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_START,  2'd3, 1'b0, 24'd4,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd0, 1'b0, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    // stop the periodic ones so the counter halts, then tick while halted
    add_row(REQ_STOP,   2'd0, 1'b1, 24'd0,       1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_STOP,   2'd2, 1'b0, 24'hFFFFFF,  1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_TICK,   2'd3, 1'b1, 24'hFFFFFF,  1'b0, 1'b0, '0, 1'b0);
    add_row(REQ_UNUSED, 2'd2, 1'b1, 24'hFFFFFF,  1'b1, 1'b0, 4'b0000, 1'b0);

    // hold reset, then release it at a falling edge
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // sender idles rarely, receiver often
    send_idle_pct = 7;
    recv_idle_pct = 75;
    write_prescale(12'd0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].chan, directed_rows[i].per,
                directed_rows[i].delay, directed_rows[i].typed, directed_rows[i].t_has,
                directed_rows[i].t_ev);
    random_run(80, 1'b1);
    drain_results();

    // the other way round; slowest prescale, then lowered below the count
    send_idle_pct = 75;
    recv_idle_pct = 7;
    write_prescale(12'd4095);
    random_run(30, 1'b0);
    drain_results();
    write_prescale(12'd1);
    random_run(110, 1'b0);
    drain_results();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_prescale(12'd2);
    random_run(55, 1'b0);
    drain_results();
    write_prescale(12'd0);
    random_run(55, 1'b0);
    drain_results();

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/mct_pkg.sv
rtl/multi_channel_compare_timer.sv
test/tb.sv
